@@ rtl/core/assert_macros.svh @@
// Assertion macros for the files of the pairwise spike accumulator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, suspended while reset is active.
`define PSIA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define PSIA_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/psia_pkg.sv @@
// Package with the constants, codes and types of the pairwise spike accumulator.
package psia_pkg;

	// Array size and counter width.
	localparam int NEURONS    = 16;
	localparam int SCORE_BITS = 24;
	localparam int PAIRS      = NEURONS * (NEURONS - 1) / 2;

	// Field widths of the input and result words.
	localparam int SPIKE_W = 16;
	localparam int PAIR_W  = 7;
	localparam int CMD_W   = 2;
	localparam int METH_W  = 2;

	// Stream word widths, padded to whole bytes.
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 32;

	// Configuration port.
	localparam int APB_ADDR_W = 2;
	localparam int APB_DATA_W = 32;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_ACC   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	// Interaction rule codes; every other code selects the signed rule.
	localparam logic [METH_W-1:0] METHOD_BOTH   = 2'd1;
	localparam logic [METH_W-1:0] METHOD_EQUAL  = 2'd2;
	localparam logic [METH_W-1:0] METHOD_SIGNED = 2'd3;
	localparam logic [METH_W-1:0] METHOD_RESET  = METHOD_BOTH;

	// Saturation bounds of a score counter.
	localparam logic signed [SCORE_BITS-1:0] SCORE_MAX = {1'b0, {(SCORE_BITS-1){1'b1}}};
	localparam logic signed [SCORE_BITS-1:0] SCORE_MIN = {1'b1, {(SCORE_BITS-1){1'b0}}};

	// Controls broadcast to every pair counter.
	typedef struct packed {
		logic              acc;
		logic              clr;
		logic [METH_W-1:0] method;
	} cell_ctrl_t;

endpackage

@@ rtl/core/pairwise_spike_interaction_accumulator.sv @@
// Top level of the pairwise spike interaction accumulator.
// The block keeps one saturating 24-bit signed score for each of the 120 pairs of
// 16 neurons, numbered i*(i-1)/2 + j for i > j. A word on the slave stream carries
// a command in tuser: accumulate one time bin of spike bits, read one pair, or
// clear all scores; only a read gives a result word on the master stream. Each word
// passes one input register, where all 120 counters update together or the pair
// select reads one, and a read then moves into the output register. The block
// takes one word every cycle unless the input stalls, and a read result is offered
// on the master stream from the output register once it has moved there.
// Only a read that finds the output register full and stalled holds up the input.
// The user must write the method register over APB only while no word is in flight; the block does not enforce it.
`include "assert_macros.svh"

module pairwise_spike_interaction_accumulator (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [psia_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [psia_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [psia_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	// Command stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// [15:0] spike_bits, [22:16] pair_index, [23] zero
	input  logic [psia_pkg::S_TDATA_W-1:0]      s_tdata,
	// [1:0] cmd
	input  logic [psia_pkg::CMD_W-1:0]          s_tuser,
	// Result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [6:0] read_pair, [30:7] score, [31] zero
	output logic [psia_pkg::M_TDATA_W-1:0]      m_tdata
);

	logic [psia_pkg::METH_W-1:0]           method;
	logic                                  valid_s1;
	logic [psia_pkg::CMD_W-1:0]            cmd_s1;
	logic [psia_pkg::SPIKE_W-1:0]          spike_s1;
	logic [psia_pkg::PAIR_W-1:0]           idx_s1;
	logic                                  read_s1;
	logic                                  out_load;
	logic                                  adv_s1;
	psia_pkg::cell_ctrl_t                  ctrl;
	logic signed [psia_pkg::SCORE_BITS-1:0] rd_score;
	logic                                  m_tvalid_q;
	logic [psia_pkg::PAIR_W-1:0]           read_pair_q;
	logic signed [psia_pkg::SCORE_BITS-1:0] score_q;

	// Configuration registers.
	psia_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.method  (method)
	);

	// Flow control: only a read waits, and only for the output register.
	assign read_s1  = valid_s1 && (cmd_s1 == psia_pkg::CMD_READ);
	assign out_load = !m_tvalid_q || m_tready;
	assign adv_s1   = !read_s1 || out_load;
	assign s_tready = adv_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && adv_s1) begin
			cmd_s1   <= s_tuser;
			spike_s1 <= s_tdata[psia_pkg::SPIKE_W-1:0];
			idx_s1   <= s_tdata[psia_pkg::SPIKE_W +: psia_pkg::PAIR_W];
		end
	end

	// Counter controls for the word in the input register.
	assign ctrl.acc    = valid_s1 && (cmd_s1 == psia_pkg::CMD_ACC);
	assign ctrl.clr    = valid_s1 && (cmd_s1 == psia_pkg::CMD_CLEAR);
	assign ctrl.method = method;

	psia_cell_array u_array (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.spike_bits (spike_s1),
		.rd_idx     (idx_s1),
		.rd_score   (rd_score)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= read_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && read_s1) begin
			read_pair_q <= idx_s1;
			score_q     <= rd_score;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, score_q, read_pair_q};

	// The input stalls only behind a read that cannot enter the output register.
	`PSIA_ASSERT(a_stall_cause, !s_tready |-> (read_s1 && m_tvalid_q && !m_tready), "input stalled without a blocked read")
	// A read that leaves the input register is offered in the next cycle.
	`PSIA_ASSERT(a_read_delivered, (read_s1 && adv_s1) |=> m_tvalid_q, "read result was not offered")
	// A pair past the last one always reads as zero.
	`PSIA_ASSERT(a_range_zero, (m_tvalid_q && (32'(read_pair_q) >= psia_pkg::PAIRS)) |-> (score_q == '0), "out-of-range pair gave a nonzero score")

endmodule

@@ rtl/core/psia_cell.sv @@
// One saturating pair counter with its interaction rule.
module psia_cell (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  psia_pkg::cell_ctrl_t                  ctrl,
	input  logic                                  spike_i,
	input  logic                                  spike_j,
	output logic signed [psia_pkg::SCORE_BITS-1:0] score
);

	logic inc;
	logic dec;
	logic signed [psia_pkg::SCORE_BITS-1:0] score_q;

	// Interaction term of this bin as an increment or a decrement.
	always_comb begin
		inc = 1'b0;
		dec = 1'b0;
		unique case (ctrl.method)
			psia_pkg::METHOD_BOTH: begin
				inc = spike_i & spike_j;
			end
			psia_pkg::METHOD_EQUAL: begin
				inc = ~(spike_i ^ spike_j);
			end
			default: begin
				inc = spike_i & spike_j;
				dec = spike_i ^ spike_j;
			end
		endcase
	end

	// Counter that stops at its signed bounds.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q <= '0;
		end else if (ctrl.clr) begin
			score_q <= '0;
		end else if (ctrl.acc) begin
			if (inc && (score_q != psia_pkg::SCORE_MAX)) begin
				score_q <= score_q + psia_pkg::SCORE_BITS'(1);
			end else if (dec && (score_q != psia_pkg::SCORE_MIN)) begin
				score_q <= score_q - psia_pkg::SCORE_BITS'(1);
			end
		end
	end

	assign score = score_q;

endmodule

@@ rtl/core/psia_cell_array.sv @@
// Row of all pair counters in lower-triangle order, with the pair readout select.
module psia_cell_array (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  psia_pkg::cell_ctrl_t                  ctrl,
	input  logic [psia_pkg::SPIKE_W-1:0]          spike_bits,
	input  logic [psia_pkg::PAIR_W-1:0]           rd_idx,
	output logic signed [psia_pkg::SCORE_BITS-1:0] rd_score
);

	logic [psia_pkg::NEURONS-1:0] spk;
	logic [psia_pkg::PAIRS-1:0][psia_pkg::SCORE_BITS-1:0] scores;

	// Neurons beyond the spike field never spike.
	for (genvar n = 0; n < psia_pkg::NEURONS; n++) begin : g_spk
		if (n < psia_pkg::SPIKE_W) begin : g_in
			assign spk[n] = spike_bits[n];
		end else begin : g_off
			assign spk[n] = 1'b0;
		end
	end

	// One counter for every pair i > j, numbered i*(i-1)/2 + j.
	for (genvar i = 1; i < psia_pkg::NEURONS; i++) begin : g_row
		for (genvar j = 0; j < i; j++) begin : g_col
			localparam int P = i * (i - 1) / 2 + j;
			psia_cell u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.ctrl    (ctrl),
				.spike_i (spk[i]),
				.spike_j (spk[j]),
				.score   (scores[P])
			);
		end
	end

	// Readout of one pair; indexes past the last pair read as zero.
	always_comb begin
		rd_score = '0;
		if (32'(rd_idx) < psia_pkg::PAIRS) begin
			rd_score = scores[rd_idx];
		end
	end

endmodule

@@ rtl/core/psia_apb_regs.sv @@
// Configuration register file behind the APB port.
module psia_apb_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [psia_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [psia_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [psia_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                 pready,
	output logic [psia_pkg::METH_W-1:0]          method
);

	logic [psia_pkg::METH_W-1:0] method_q;
	logic                        wr_en;

	// The only register holds the method in the low bits of the word; the address is ignored.
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= psia_pkg::METHOD_RESET;
		end else if (wr_en) begin
			method_q <= pwdata[psia_pkg::METH_W-1:0];
		end
	end

	// Read data, with the byte offset ignored as on writes.
	always_comb begin
		prdata = '0;
		if (paddr <= psia_pkg::APB_ADDR_W'(3)) begin
			prdata = psia_pkg::APB_DATA_W'(method_q);
		end
	end

	assign method = method_q;

endmodule

@@ verif/spike_score_checker.sv @@
`timescale 1ns / 100ps
// Checker that tracks pair scores and compares every result word of the accumulator.
module spike_score_checker
	import psia_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [APB_ADDR_W-1:0]   paddr,
	input  logic [APB_DATA_W-1:0]   pwdata,
	input  logic [APB_DATA_W-1:0]   prdata,
	input  logic                    pready,
	input  logic                    s_tvalid,
	input  logic                    s_tready,
	// [15:0] spike_bits, [22:16] pair_index, [23] zero
	input  logic [S_TDATA_W-1:0]    s_tdata,
	// [1:0] cmd
	input  logic [CMD_W-1:0]        s_tuser,
	input  logic                    m_tvalid,
	input  logic                    m_tready,
	// [6:0] read_pair, [30:7] score, [31] zero
	input  logic [M_TDATA_W-1:0]    m_tdata,
	output int                      mismatch_count,
	output int                      pending_reads
);

	localparam logic [APB_ADDR_W-1:0] ADDR_METHOD = '0;

	typedef struct {
		logic [PAIR_W-1:0]            pair;
		logic signed [SCORE_BITS-1:0] score;
	} score_word_t;

	// Predicted state of the block.
	logic signed [SCORE_BITS-1:0] pair_score [PAIRS];
	logic [METH_W-1:0]            method_reg;
	score_word_t                  score_words [$];

	score_word_t                  want;
	logic [PAIR_W-1:0]            got_pair;
	logic [SCORE_BITS-1:0]        got_score;
	logic [PAIR_W-1:0]            read_idx;

	// One line per mismatch, and the count goes up.
	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	// Contribution of one neuron pair to its score for the given rule.
	function automatic longint pair_term(input logic [METH_W-1:0] rule_code, input logic a,
			input logic b);
		case (rule_code)
			METHOD_BOTH: return (a && b) ? 1 : 0;
			METHOD_EQUAL: return (a == b) ? 1 : 0;
			default: begin
				// Any other code, zero included, selects the signed rule.
				if (a && b)
					return 1;
				else if (a != b)
					return -1;
				return 0;
			end
		endcase
	endfunction

	// Neurons beyond the spike field never spike.
	function automatic logic spike_at(input logic [SPIKE_W-1:0] bits, input int n);
		if (n >= SPIKE_W)
			return 1'b0;
		return bits[n];
	endfunction

	// One time bin: every pair counter moves by its term and saturates.
	task automatic accumulate_bin(input logic [SPIKE_W-1:0] bits);
		int     p;
		longint sum;
		p = 0;
		for (int i = 1; i < NEURONS; i++) begin
			for (int j = 0; j < i; j++) begin
				sum = longint'(pair_score[p]) +
					pair_term(method_reg, spike_at(bits, i), spike_at(bits, j));
				if (sum > longint'(SCORE_MAX))
					sum = longint'(SCORE_MAX);
				if (sum < longint'(SCORE_MIN))
					sum = longint'(SCORE_MIN);
				pair_score[p] = sum[SCORE_BITS-1:0];
				p++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (pair_score[k])
				pair_score[k] = '0;
			method_reg = METHOD_RESET;
			score_words.delete();
			mismatch_count = 0;
		end else begin
			// Register access on the configuration port.
			if (psel && penable && pready) begin
				if (pwrite) begin
					if (paddr == ADDR_METHOD)
						method_reg = pwdata[METH_W-1:0];
				end else if (prdata !== APB_DATA_W'(method_reg)) begin
					report_mismatch($sformatf("method read back %0h, expected %0h",
						prdata, method_reg));
				end
			end

			// Result word against the oldest pending read.
			if (m_tvalid && m_tready) begin
				got_pair  = m_tdata[PAIR_W-1:0];
				got_score = m_tdata[PAIR_W +: SCORE_BITS];
				if (score_words.size() == 0) begin
					report_mismatch($sformatf("result word with no read pending: pair %0d",
						got_pair));
				end else begin
					want = score_words.pop_front();
					if (got_pair !== want.pair)
						report_mismatch($sformatf("read_pair %0d, expected %0d",
							got_pair, want.pair));
					if (got_score !== want.score)
						report_mismatch($sformatf("score of pair %0d is %0d, expected %0d",
							want.pair, $signed(got_score), want.score));
				end
			end

			// Command word entering the block.
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					CMD_ACC: accumulate_bin(s_tdata[SPIKE_W-1:0]);
					CMD_READ: begin
						read_idx   = s_tdata[SPIKE_W +: PAIR_W];
						want.pair  = read_idx;
						want.score = (read_idx < PAIRS) ? pair_score[read_idx] : '0;
						score_words.push_back(want);
					end
					CMD_CLEAR: begin
						foreach (pair_score[k])
							pair_score[k] = '0;
					end
					default: ;
				endcase
			end
		end
		pending_reads = score_words.size();
	end

endmodule

@@ verif/pairwise_spike_interaction_accumulator_tb.sv @@
`timescale 1ns / 100ps
// Testbench top that drives the pairwise spike accumulator and reports the verdict.
module pairwise_spike_interaction_accumulator_tb;
	import psia_pkg::*;

	localparam logic [CMD_W-1:0]      CMD_IGNORED = 2'd3;
	localparam logic [METH_W-1:0]     METHOD_ZERO = 2'd0;
	localparam logic [APB_ADDR_W-1:0] ADDR_METHOD = '0;
	localparam int PHASES       = 8;
	localparam int PHASE_WORDS  = 216;
	localparam int HOLD_PHASE   = 2;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 6;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid;
	logic                  s_tready;
	// [15:0] spike_bits, [22:16] pair_index, [23] zero
	logic [S_TDATA_W-1:0]  s_tdata;
	// [1:0] cmd
	logic [CMD_W-1:0]      s_tuser;
	logic                  m_tvalid;
	logic                  m_tready;
	// [6:0] read_pair, [30:7] score, [31] zero
	logic [M_TDATA_W-1:0]  m_tdata;

	int   mismatch_count;
	int   pending_reads;
	int   burst_left;
	int   gap_max;
	logic hold_request;
	logic hold_done;

	logic [METH_W-1:0] first_methods [4] = '{METHOD_EQUAL, METHOD_SIGNED, METHOD_ZERO,
		METHOD_BOTH};

	pairwise_spike_interaction_accumulator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	spike_score_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.mismatch_count (mismatch_count),
		.pending_reads  (pending_reads)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// Receiver: random stall modes that change from span to span, plus one long hold-off.
	initial begin
		int mode;
		int span;
		m_tready  = 1'b0;
		hold_done = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = $urandom_range(0, 2);
			span = $urandom_range(20, 120);
			repeat (span) begin
				@(negedge clk);
				if (hold_request && !hold_done) begin
					m_tready <= 1'b0;
					repeat (HOLD_CYCLES - 1) @(negedge clk);
					hold_done = 1'b1;
				end else begin
					case (mode)
						0: m_tready <= 1'b1;
						1: m_tready <= 1'($urandom_range(0, 1));
						default: m_tready <= ($urandom_range(0, 3) == 0);
					endcase
				end
			end
		end
	end

	// One register access: setup cycle, then access cycle until pready.
	task automatic apb_access(input logic write_en, input logic [METH_W-1:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= write_en;
		paddr   <= ADDR_METHOD;
		pwdata  <= ($urandom & ~32'h3) | APB_DATA_W'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Offer one word, with a random gap whenever a burst runs out.
	task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [SPIKE_W-1:0] bits,
			input logic [PAIR_W-1:0] idx);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(0, gap_max);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				s_tdata  <= {1'b0, 7'($urandom), 16'($urandom)};
				s_tuser  <= 2'($urandom);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {1'b0, idx, bits};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Random spike vector: uniform, sparse, dense or a single neuron.
	function automatic logic [SPIKE_W-1:0] random_spikes();
		case ($urandom_range(0, 3))
			0: return SPIKE_W'($urandom);
			1: return SPIKE_W'($urandom & $urandom & $urandom);
			2: return SPIKE_W'($urandom | $urandom | $urandom);
			default: return SPIKE_W'(1) << $urandom_range(0, SPIKE_W - 1);
		endcase
	endfunction

	// Stop offering, wait for every read result, then let the pipeline settle.
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_reads != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Stimulus and verdict.
	initial begin
		int               counted;
		int               pick;
		logic [CMD_W-1:0] cmd;
		logic [PAIR_W-1:0] idx;
		logic [METH_W-1:0] method_now;

		arst_n       = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		hold_request = 1'b0;
		burst_left   = 0;
		gap_max      = 2;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Reset value of the method register, then the directed words under the both-spike rule.
		apb_access(1'b0, METHOD_RESET);
		send_word(CMD_READ, 16'($urandom), 7'd0);
		send_word(CMD_ACC, 16'hFFFF, 7'($urandom));
		send_word(CMD_ACC, 16'h0000, 7'($urandom));
		send_word(CMD_ACC, 16'h8001, 7'($urandom));
		send_word(CMD_ACC, 16'hAAAA, 7'($urandom));
		send_word(CMD_ACC, 16'h5555, 7'($urandom));
		send_word(CMD_READ, 16'($urandom), 7'd0);
		send_word(CMD_READ, 16'($urandom), 7'd105);
		send_word(CMD_READ, 16'($urandom), 7'(PAIRS - 1));
		// Indexes past the last pair read as zero.
		send_word(CMD_READ, 16'($urandom), 7'(PAIRS));
		send_word(CMD_READ, 16'($urandom), 7'h7F);
		// The unused command must leave the scores alone.
		send_word(CMD_IGNORED, 16'hFFFF, 7'd0);
		send_word(CMD_READ, 16'($urandom), 7'd0);
		send_word(CMD_CLEAR, 16'hFFFF, 7'h7F);
		send_word(CMD_READ, 16'($urandom), 7'd0);
		send_word(CMD_READ, 16'($urandom), 7'(PAIRS - 1));
		drain();

		// Random phases, each under its own method setting.
		for (int ph = 0; ph < PHASES; ph++) begin
			method_now = (ph < 4) ? first_methods[ph] : METH_W'($urandom_range(0, 3));
			apb_access(1'b1, method_now);
			apb_access(1'b0, method_now);
			case (ph % 3)
				0: gap_max = 0;
				1: gap_max = 3;
				default: gap_max = 10;
			endcase
			if (ph == HOLD_PHASE)
				hold_request = 1'b1;
			counted = 0;
			while (counted < PHASE_WORDS) begin
				pick = $urandom_range(0, 99);
				if (pick < 55)
					cmd = CMD_ACC;
				else if (pick < 90)
					cmd = CMD_READ;
				else if (pick < 94)
					cmd = CMD_CLEAR;
				else
					cmd = CMD_IGNORED;
				idx = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(PAIRS, 127))
					: 7'($urandom_range(0, PAIRS - 1));
				send_word(cmd, random_spikes(), idx);
				if (cmd != CMD_IGNORED)
					counted++;
			end
			drain();
		end

		if (mismatch_count == 0 && pending_reads == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
